[hdl/pmm_pkg.sv]
// ----------------------------------------------------------------------------
// pmm_pkg: shared types and constants of the pixel min/max normalizer
// Sample width, action codes, store word layout and the payload structs that
// pass between the store stage, the divider and the result queue.
// ----------------------------------------------------------------------------
package pmm_pkg;

   localparam int PIX_BITS   = 10;
   localparam int MIN_W      = PIX_BITS + 1;
   localparam int INDEX_W    = 16;
   localparam int ACT_W      = 2;
   localparam int WORD_W     = MIN_W + PIX_BITS;
   localparam int NUM_W      = 2 * PIX_BITS;
   localparam int DIV_STAGES = PIX_BITS;

   // result queue must cover every beat in flight from accept to pop
   localparam int FIFO_DEPTH = 16;
   localparam int FIFO_PTR_W = 4;
   localparam logic [FIFO_PTR_W:0] CREDIT_FULL = (FIFO_PTR_W + 1)'(FIFO_DEPTH);

   typedef logic [ACT_W-1:0] pmm_action_type;

   localparam pmm_action_type ACT_FOLD  = 2'd0;
   localparam pmm_action_type ACT_NORM  = 2'd1;
   localparam pmm_action_type ACT_CLEAR = 2'd2;

   localparam logic [MIN_W-1:0]    EMPTY_MIN  = {1'b1, {PIX_BITS{1'b0}}};
   localparam logic [PIX_BITS-1:0] EMPTY_MAX  = '0;
   localparam logic [WORD_W-1:0]   CLEAR_WORD = {EMPTY_MIN, EMPTY_MAX};

   typedef struct packed {
      logic [PIX_BITS-1:0] pixel;
      logic [MIN_W-1:0]    lo;
      logic [PIX_BITS-1:0] hi;
      logic                do_norm;
   } pmm_calc_type;

   typedef struct packed {
      logic [PIX_BITS-1:0] norm_value;
      logic [MIN_W-1:0]    min_value;
      logic [PIX_BITS-1:0] max_value;
      logic                zero_range;
   } pmm_rsp_type;

endpackage

[hdl/pmm_if.sv]
// ----------------------------------------------------------------------------
// pmm_if: request and response channels of the pixel min/max normalizer
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pmm_req_if import pmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACT_W-1:0]    action;
   logic [INDEX_W-1:0]  pixel_index;
   logic [PIX_BITS-1:0] pixel_value;

   modport source (output valid, output action, output pixel_index, output pixel_value,
                   input ready);
   modport sink   (input valid, input action, input pixel_index, input pixel_value,
                   output ready);
endinterface

interface pmm_rsp_if import pmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [PIX_BITS-1:0] norm_value;
   logic [MIN_W-1:0]    min_value;
   logic [PIX_BITS-1:0] max_value;
   logic                zero_range;

   modport source (output valid, output norm_value, output min_value, output max_value,
                   output zero_range, input ready);
   modport sink   (input valid, input norm_value, input min_value, input max_value,
                   input zero_range, output ready);
endinterface

[hdl/pixel_minmax_normalizer.sv]
// ----------------------------------------------------------------------------
// pixel_minmax_normalizer: per-pixel running min/max and normalization
// Keeps a minimum and maximum for every pixel of a frame in one RAM word per
// pixel. A fold beat merges the sample into its pixel's range, a clear beat
// empties the entry (min 1024, max 0), and a normalize beat returns
// floor((p-min)*1023/(max-min)) with the sample clamped into [min,max], or 0
// with zero_range set when max is not above min. Each beat yields one result
// carrying the pixel's min and max after the beat; an index at or beyond
// PIXEL_COUNT touches nothing and reports an empty range. The block takes one
// beat per cycle while req_ch.ready is high. A result is offered on rsp_ch
// after its beat passes the store stage, which modifies, clamps and scales the
// RAM word read at the accept edge, a 10-stage restoring divider and a write
// into the 16-entry result queue, which absorbs output stalls. Back-to-back
// beats to the same pixel are forwarded around the RAM.
// After reset the RAM is swept clear, one entry per cycle, across all
// min(PIXEL_COUNT, 65536) entries, during which req_ch.ready stays low.
// ----------------------------------------------------------------------------
module pixel_minmax_normalizer import pmm_pkg::*; #(
   parameter int unsigned PIXEL_COUNT = 65536
) (
   input logic        clock,
   input logic        reset,
   pmm_req_if.sink    req_ch,
   pmm_rsp_if.source  rsp_ch
);

   localparam int unsigned INDEX_SPAN = 32'd1 << INDEX_W;
   localparam int unsigned DEPTH      = (PIXEL_COUNT > INDEX_SPAN) ? INDEX_SPAN : PIXEL_COUNT;
   localparam int          ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic accept;
   logic pop;

   // clearing sweep
   logic              clr_busy_ff;
   logic              clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [ADDR_W-1:0] clr_addr_in;

   // request side
   logic [ADDR_W-1:0] req_addr;
   logic              req_in_range;

   // read-modify-write stage
   logic                s1_valid_ff;
   pmm_action_type      s1_action_ff;
   logic [ADDR_W-1:0]   s1_addr_ff;
   logic [PIX_BITS-1:0] s1_pixel_ff;
   logic                s1_in_range_ff;
   logic                s1_fwd_ff;
   logic                s1_fwd_in;
   logic [WORD_W-1:0]   fwd_word_ff;

   logic [WORD_W-1:0]   rd_word;
   logic [WORD_W-1:0]   cur_word;
   logic [MIN_W-1:0]    cur_lo;
   logic [PIX_BITS-1:0] cur_hi;
   logic [MIN_W-1:0]    new_lo;
   logic [PIX_BITS-1:0] new_hi;
   logic                s1_wr;

   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [WORD_W-1:0] ram_wr_data;

   pmm_calc_type calc;
   logic         div_valid;
   pmm_rsp_type  div_rsp;

   // result queue and credit count
   pmm_rsp_type           fifo_mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_in;
   logic [FIFO_PTR_W:0]   fifo_cnt_ff;
   logic [FIFO_PTR_W:0]   fifo_cnt_in;
   logic [FIFO_PTR_W:0]   credit_ff;
   logic [FIFO_PTR_W:0]   credit_in;
   pmm_rsp_type           head;

   assign req_ch.ready = !clr_busy_ff && (credit_ff != CREDIT_FULL);
   assign accept       = req_ch.valid && req_ch.ready;
   assign pop          = rsp_ch.valid && rsp_ch.ready;

   // ---------------------------------------------------------------- clear
   assign clr_busy_in = clr_busy_ff && (clr_addr_ff != LAST_ADDR);
   assign clr_addr_in = clr_busy_ff ? (clr_addr_ff + ADDR_W'(1)) : clr_addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // ---------------------------------------------------------------- store
   assign req_addr     = req_ch.pixel_index[ADDR_W-1:0];
   assign req_in_range = 32'(req_ch.pixel_index) < PIXEL_COUNT;

   // the beat now writing lands on the same edge as this read: take its word
   assign s1_fwd_in = s1_wr && (s1_addr_ff == req_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff   <= req_ch.action;
         s1_addr_ff     <= req_addr;
         s1_pixel_ff    <= req_ch.pixel_value;
         s1_in_range_ff <= req_in_range;
         s1_fwd_ff      <= s1_fwd_in;
         fwd_word_ff    <= {new_lo, new_hi};
      end
   end

   pmm_ram #(
      .WIDTH  (WORD_W),
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_word)
   );

   always_comb begin
      cur_word = s1_fwd_ff ? fwd_word_ff : rd_word;
      cur_lo   = cur_word[WORD_W-1 -: MIN_W];
      cur_hi   = cur_word[PIX_BITS-1:0];
      case (s1_action_ff)
         ACT_FOLD: begin
            new_lo = ({1'b0, s1_pixel_ff} < cur_lo) ? {1'b0, s1_pixel_ff} : cur_lo;
            new_hi = (s1_pixel_ff > cur_hi) ? s1_pixel_ff : cur_hi;
         end
         ACT_CLEAR: begin
            new_lo = EMPTY_MIN;
            new_hi = EMPTY_MAX;
         end
         default: begin
            new_lo = cur_lo;
            new_hi = cur_hi;
         end
      endcase
      s1_wr = s1_valid_ff && s1_in_range_ff &&
              ((s1_action_ff == ACT_FOLD) || (s1_action_ff == ACT_CLEAR));
   end

   always_comb begin
      if (clr_busy_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_addr_ff;
         ram_wr_data = CLEAR_WORD;
      end else begin
         ram_wr_en   = s1_wr;
         ram_wr_addr = s1_addr_ff;
         ram_wr_data = {new_lo, new_hi};
      end
   end

   // out-of-range beats report an empty range and never normalize
   assign calc.pixel   = s1_pixel_ff;
   assign calc.lo      = s1_in_range_ff ? new_lo : EMPTY_MIN;
   assign calc.hi      = s1_in_range_ff ? new_hi : EMPTY_MAX;
   assign calc.do_norm = s1_in_range_ff && (s1_action_ff == ACT_NORM);

   pmm_norm_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_calc   (calc),
      .out_valid (div_valid),
      .out_rsp   (div_rsp)
   );

   // ---------------------------------------------------------------- queue
   assign wr_ptr_in   = div_valid ? (wr_ptr_ff + FIFO_PTR_W'(1)) : wr_ptr_ff;
   assign rd_ptr_in   = pop ? (rd_ptr_ff + FIFO_PTR_W'(1)) : rd_ptr_ff;
   assign fifo_cnt_in = fifo_cnt_ff + (FIFO_PTR_W + 1)'(div_valid)
                        - (FIFO_PTR_W + 1)'(pop);
   assign credit_in   = credit_ff + (FIFO_PTR_W + 1)'(accept)
                        - (FIFO_PTR_W + 1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         fifo_cnt_ff <= '0;
         credit_ff   <= '0;
      end else begin
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         fifo_cnt_ff <= fifo_cnt_in;
         credit_ff   <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_valid) begin
         fifo_mem_ff[wr_ptr_ff] <= div_rsp;
      end
   end

   assign head              = fifo_mem_ff[rd_ptr_ff];
   assign rsp_ch.valid      = fifo_cnt_ff != '0;
   assign rsp_ch.norm_value = head.norm_value;
   assign rsp_ch.min_value  = head.min_value;
   assign rsp_ch.max_value  = head.max_value;
   assign rsp_ch.zero_range = head.zero_range;

endmodule

[hdl/pmm_ram.sv]
// ----------------------------------------------------------------------------
// pmm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data (old data on a
// read of the address being written in the same cycle).
// ----------------------------------------------------------------------------
module pmm_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[hdl/pmm_norm_div.sv]
// ----------------------------------------------------------------------------
// pmm_norm_div: normalization datapath
// Clamps the sample into [min,max], forms (p-min)*(2^PIX_BITS-1) and divides it by
// (max-min) in a restoring divider of one quotient bit per stage.
// ----------------------------------------------------------------------------
module pmm_norm_div import pmm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   input  pmm_calc_type in_calc,
   output logic         out_valid,
   output pmm_rsp_type  out_rsp
);

   logic [DIV_STAGES:0] valid_ff;
   logic [DIV_STAGES:0] valid_in;

   logic [NUM_W-1:0]    rem_ff  [DIV_STAGES];
   logic [PIX_BITS-1:0] dvs_ff  [DIV_STAGES];
   logic [PIX_BITS-1:0] quo_ff  [DIV_STAGES+1];
   logic [MIN_W-1:0]    lo_ff   [DIV_STAGES+1];
   logic [PIX_BITS-1:0] hi_ff   [DIV_STAGES+1];
   logic                flat_ff [DIV_STAGES+1];

   logic                has_span;
   logic                do_div;
   logic [PIX_BITS-1:0] lo_short;
   logic [PIX_BITS-1:0] clamp_pix;
   logic [PIX_BITS-1:0] offset;
   logic [NUM_W-1:0]    rem0_in;
   logic [PIX_BITS-1:0] dvs0_in;
   logic                flat0_in;

   assign valid_in = {valid_ff[DIV_STAGES-1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // with a real span the minimum is below 2^PIX_BITS, so its low bits carry it
   always_comb begin
      has_span = {1'b0, in_calc.hi} > in_calc.lo;
      do_div   = in_calc.do_norm && has_span;
      lo_short = in_calc.lo[PIX_BITS-1:0];
      if (in_calc.pixel < lo_short) begin
         clamp_pix = lo_short;
      end else if (in_calc.pixel > in_calc.hi) begin
         clamp_pix = in_calc.hi;
      end else begin
         clamp_pix = in_calc.pixel;
      end
      offset = clamp_pix - lo_short;
      if (do_div) begin
         rem0_in = (NUM_W'(offset) << PIX_BITS) - NUM_W'(offset);
         dvs0_in = in_calc.hi - lo_short;
      end else begin
         rem0_in = '0;
         dvs0_in = PIX_BITS'(1);
      end
      flat0_in = in_calc.do_norm && !has_span;
   end

   always_ff @(posedge clock) begin
      rem_ff[0]  <= rem0_in;
      dvs_ff[0]  <= dvs0_in;
      quo_ff[0]  <= '0;
      lo_ff[0]   <= in_calc.lo;
      hi_ff[0]   <= in_calc.hi;
      flat_ff[0] <= flat0_in;
   end

   for (genvar g = 1; g <= DIV_STAGES; g++) begin : g_stage
      logic [NUM_W-1:0]    trial;
      logic                take;
      logic [PIX_BITS-1:0] quo_in;

      // quotient below 2^PIX_BITS: test divisor scaled by the bit weight
      assign trial  = NUM_W'(dvs_ff[g-1]) << (DIV_STAGES - g);
      assign take   = rem_ff[g-1] >= trial;
      assign quo_in = {quo_ff[g-1][PIX_BITS-2:0], take};

      always_ff @(posedge clock) begin
         quo_ff[g]  <= quo_in;
         lo_ff[g]   <= lo_ff[g-1];
         hi_ff[g]   <= hi_ff[g-1];
         flat_ff[g] <= flat_ff[g-1];
      end

      if (g < DIV_STAGES) begin : g_carry
         logic [NUM_W-1:0] rem_in;

         assign rem_in = take ? (rem_ff[g-1] - trial) : rem_ff[g-1];

         always_ff @(posedge clock) begin
            rem_ff[g] <= rem_in;
            dvs_ff[g] <= dvs_ff[g-1];
         end
      end
   end

   assign out_valid          = valid_ff[DIV_STAGES];
   assign out_rsp.norm_value = quo_ff[DIV_STAGES];
   assign out_rsp.min_value  = lo_ff[DIV_STAGES];
   assign out_rsp.max_value  = hi_ff[DIV_STAGES];
   assign out_rsp.zero_range = flat_ff[DIV_STAGES];

endmodule
